[rtl/btc_pkg.sv]
package btc_pkg;

  localparam int unsigned RAW_W     = 20;
  localparam int unsigned READING_W = 19;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned DIV_W     = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIM_1_2  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIM_3    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM_1_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM_3_4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM_5_6 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM_7_8 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TRIM_9   = 3'd6;

  localparam logic                KIND_TEMP  = 1'b0;
  localparam logic                KIND_PRESS = 1'b1;

  localparam logic signed [31:0]  TEMP_MAX   = 32'sd32767;
  localparam logic signed [31:0]  TEMP_MIN   = -32'sd32768;
  localparam logic [31:0]         PRESS_MAX  = 32'd262143;
  localparam logic signed [31:0]  FINE_OFS   = 32'sd64000;
  localparam logic [31:0]         PRESS_BASE = 32'd1048576;
  localparam logic [31:0]         PRESS_MUL  = 32'd3125;
  localparam logic signed [31:0]  P1_OFS     = 32'sd32768;
  localparam logic [31:0]         TEMP_RND   = 32'd128;

  // side data that rides along with an item after the fine temperature
  typedef struct packed {
    logic                        kind;
    logic signed [READING_W-1:0] temp;
  } side_t;

  // divider stage control
  typedef struct packed {
    logic  invalid;
    logic  mode;    // 1: numerator was too big to pre-double, double afterwards
    side_t side;
  } div_side_t;

endpackage

[rtl/btc_stream_if.sv]
interface btc_in_if;
  import btc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [RAW_W-1:0]     raw_temp;
  logic [RAW_W-1:0]     raw_press;
  modport source (output valid, kind, raw_temp, raw_press, input ready);
  modport sink   (input valid, kind, raw_temp, raw_press, output ready);
endinterface

interface btc_out_if;
  import btc_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [READING_W-1:0] reading;
  logic                        invalid;
  modport source (output valid, reading, invalid, input ready);
  modport sink   (input valid, reading, invalid, output ready);
endinterface

interface btc_cfg_if;
  import btc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/baro_temp_compensation.sv]
// Barometric sensor trim compensation, 32-bit integer datapath.
// Channels:
//   in_req  - request: kind (0 temperature, 1 pressure), raw_temp, raw_press.
//   out_rsp - one result per request: reading (0.01 degC or Pa) and invalid.
//   cfg_req - trim register writes, index 0..6; cfg_req.ready is always high.
//             Write only while no request is in flight.
// Throughput: one request per cycle while the output is not stalled. The depth
// is set by the 32-stage restoring divider (one quotient bit per stage) plus
// 14 multiply/shift stages around it.
// Every stage holds when the output register is full and not taken, so
// in_req.ready = !out_rsp.valid || out_rsp.ready; nothing is dropped or
// repeated under stall.
// Reset (rst_n low, synchronous) clears all stage valid bits and the trim
// registers to zero. Trim words T1 and P1 are unsigned, all others signed.
// A zero pressure divisor returns reading 0 with invalid set.
module baro_temp_compensation
  import btc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  btc_in_if.sink    in_req,
  btc_out_if.source out_rsp,
  btc_cfg_if.sink   cfg_req
);

  // ---------------- configuration ----------------
  logic [31:0] tt12_r, pt12_r, pt34_r, pt56_r, pt78_r;
  logic [15:0] tt3_r, pt9_r;

  assign cfg_req.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tt12_r <= '0; tt3_r <= '0; pt12_r <= '0; pt34_r <= '0;
      pt56_r <= '0; pt78_r <= '0; pt9_r <= '0;
    end else if (cfg_req.valid) begin
      unique case (cfg_req.index)
        REG_TEMP_TRIM_1_2:  tt12_r <= cfg_req.data;
        REG_TEMP_TRIM_3:    tt3_r  <= cfg_req.data[15:0];
        REG_PRESS_TRIM_1_2: pt12_r <= cfg_req.data;
        REG_PRESS_TRIM_3_4: pt34_r <= cfg_req.data;
        REG_PRESS_TRIM_5_6: pt56_r <= cfg_req.data;
        REG_PRESS_TRIM_7_8: pt78_r <= cfg_req.data;
        REG_PRESS_TRIM_9:   pt9_r  <= cfg_req.data[15:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = tt12_r[15:0];
  assign t2 = tt12_r[31:16];
  assign t3 = tt3_r;
  assign p1 = pt12_r[15:0];
  assign p2 = pt12_r[31:16];
  assign p3 = pt34_r[15:0];
  assign p4 = pt34_r[31:16];
  assign p5 = pt56_r[15:0];
  assign p6 = pt56_r[31:16];
  assign p7 = pt78_r[15:0];
  assign p8 = pt78_r[31:16];
  assign p9 = pt9_r;

  // ---------------- flow control ----------------
  logic out_valid_r;
  logic adv;
  assign adv          = !out_valid_r || out_rsp.ready;
  assign in_req.ready = adv;

  // ---------------- S1: offsets from raw temperature ----------------
  logic              s1_v_r, s1_kind_r;
  logic [RAW_W-1:0]  s1_ap_r;
  logic [31:0]       s1_x_r, s1_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= in_req.valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r <= in_req.kind;
      s1_ap_r   <= in_req.raw_press;
      s1_x_r    <= {15'd0, in_req.raw_temp[19:3]} - {15'd0, t1, 1'b0};
      s1_d_r    <= {16'd0, in_req.raw_temp[19:4]} - {16'd0, t1};
    end
  end

  // ---------------- S2: x*T2, d*d ----------------
  logic              s2_v_r, s2_kind_r;
  logic [RAW_W-1:0]  s2_ap_r;
  logic [31:0]       s2_m1_r, s2_dd_r;
  logic signed [47:0] s2_m1;
  logic [63:0]        s2_dd;
  assign s2_m1 = $signed(s1_x_r) * t2;
  assign s2_dd = s1_d_r * s1_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind_r <= s1_kind_r;
      s2_ap_r   <= s1_ap_r;
      s2_m1_r   <= s2_m1[31:0];
      s2_dd_r   <= s2_dd[31:0];
    end
  end

  // ---------------- S3: var1, (dd>>12)*T3 ----------------
  logic              s3_v_r, s3_kind_r;
  logic [RAW_W-1:0]  s3_ap_r;
  logic [31:0]       s3_v1_r, s3_e_r;
  logic signed [31:0] s3_dsh;
  logic signed [47:0] s3_e;
  assign s3_dsh = $signed(s2_dd_r) >>> 12;
  assign s3_e   = s3_dsh * t3;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_kind_r <= s2_kind_r;
      s3_ap_r   <= s2_ap_r;
      s3_v1_r   <= $signed(s2_m1_r) >>> 11;
      s3_e_r    <= s3_e[31:0];
    end
  end

  // ---------------- S4: fine temperature ----------------
  logic              s4_v_r, s4_kind_r;
  logic [RAW_W-1:0]  s4_ap_r;
  logic [31:0]       s4_fine_r;
  logic [31:0]       s4_e_sh;
  assign s4_e_sh = $signed(s3_e_r) >>> 14;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= s3_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_kind_r <= s3_kind_r;
      s4_ap_r   <= s3_ap_r;
      s4_fine_r <= s3_v1_r + s4_e_sh;
    end
  end

  // ---------------- S5: temperature result, pressure var1 ----------------
  logic              s5_v_r;
  side_t             s5_side_r;
  logic [RAW_W-1:0]  s5_ap_r;
  logic [31:0]       s5_pv1_r, s5_q0_r;
  logic [31:0]       s5_tm, s5_pv1;
  logic signed [31:0] s5_t;
  logic signed [READING_W-1:0] s5_tsat;

  assign s5_tm  = s4_fine_r * 32'd5 + TEMP_RND;
  assign s5_t   = $signed(s5_tm) >>> 8;
  assign s5_pv1 = ($signed(s4_fine_r) >>> 1) - FINE_OFS;

  always_comb begin
    priority if (s5_t > TEMP_MAX) s5_tsat = READING_W'(TEMP_MAX);
    else if (s5_t < TEMP_MIN)     s5_tsat = READING_W'(TEMP_MIN);
    else                          s5_tsat = s5_t[READING_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (adv) s5_v_r <= s4_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_side_r.kind <= s4_kind_r;
      s5_side_r.temp <= s5_tsat;
      s5_ap_r        <= s4_ap_r;
      s5_pv1_r       <= s5_pv1;
      s5_q0_r        <= $signed(s5_pv1) >>> 2;
    end
  end

  // ---------------- S6: q = q0^2, a = var1*P5 ----------------
  logic              s6_v_r;
  side_t             s6_side_r;
  logic [RAW_W-1:0]  s6_ap_r;
  logic [31:0]       s6_pv1_r, s6_q_r, s6_a_r;
  logic [63:0]       s6_q;
  logic signed [47:0] s6_a;
  assign s6_q = s5_q0_r * s5_q0_r;
  assign s6_a = $signed(s5_pv1_r) * p5;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else if (adv) s6_v_r <= s5_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_side_r <= s5_side_r;
      s6_ap_r   <= s5_ap_r;
      s6_pv1_r  <= s5_pv1_r;
      s6_q_r    <= s6_q[31:0];
      s6_a_r    <= s6_a[31:0];
    end
  end

  // ---------------- S7: products with P6, P3, P2 ----------------
  logic              s7_v_r;
  side_t             s7_side_r;
  logic [RAW_W-1:0]  s7_ap_r;
  logic [31:0]       s7_a_r, s7_b_r, s7_c_r, s7_g_r;
  logic signed [31:0] s7_q11, s7_q13;
  logic signed [47:0] s7_b, s7_c, s7_g;
  assign s7_q11 = $signed(s6_q_r) >>> 11;
  assign s7_q13 = $signed(s6_q_r) >>> 13;
  assign s7_b   = s7_q11 * p6;
  assign s7_c   = s7_q13 * p3;
  assign s7_g   = $signed(s6_pv1_r) * p2;

  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else if (adv) s7_v_r <= s6_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_side_r <= s6_side_r;
      s7_ap_r   <= s6_ap_r;
      s7_a_r    <= s6_a_r;
      s7_b_r    <= s7_b[31:0];
      s7_c_r    <= s7_c[31:0];
      s7_g_r    <= s7_g[31:0];
    end
  end

  // ---------------- S8: var2 and var1 sums ----------------
  logic              s8_v_r;
  side_t             s8_side_r;
  logic [RAW_W-1:0]  s8_ap_r;
  logic [31:0]       s8_v2_r, s8_v1_r;
  logic [31:0]       s8_sum2, s8_sum1;
  assign s8_sum2 = s7_b_r + {s7_a_r[30:0], 1'b0};
  assign s8_sum1 = ($signed(s7_c_r) >>> 3) + ($signed(s7_g_r) >>> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) s8_v_r <= 1'b0;
    else if (adv) s8_v_r <= s7_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s8_side_r <= s7_side_r;
      s8_ap_r   <= s7_ap_r;
      // signed sum keeps the shift arithmetic
      s8_v2_r   <= ($signed(s8_sum2) >>> 2) + $signed({p4, 16'd0});
      s8_v1_r   <= $signed(s8_sum1) >>> 18;
    end
  end

  // ---------------- S9: (32768+var1)*P1, pressure base ----------------
  logic              s9_v_r;
  side_t             s9_side_r;
  logic [31:0]       s9_m_r, s9_pb_r;
  logic [31:0]       s9_v2sh;
  logic signed [63:0] s9_m;
  assign s9_m    = $signed(s8_v1_r + P1_OFS) * $signed({16'd0, p1});
  assign s9_v2sh = $signed(s8_v2_r) >>> 12;

  always_ff @(posedge clk) begin
    if (!rst_n) s9_v_r <= 1'b0;
    else if (adv) s9_v_r <= s8_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s9_side_r <= s8_side_r;
      s9_m_r    <= s9_m[31:0];
      s9_pb_r   <= PRESS_BASE - {12'd0, s8_ap_r} - s9_v2sh;
    end
  end

  // ---------------- S10: divisor, numerator * 3125 ----------------
  logic              s10_v_r;
  side_t             s10_side_r;
  logic [31:0]       s10_div_r, s10_pm_r;
  logic [63:0]       s10_pm;
  assign s10_pm = s9_pb_r * PRESS_MUL;

  always_ff @(posedge clk) begin
    if (!rst_n) s10_v_r <= 1'b0;
    else if (adv) s10_v_r <= s9_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s10_side_r <= s9_side_r;
      s10_div_r  <= $signed(s9_m_r) >>> 15;
      s10_pm_r   <= s10_pm[31:0];
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  logic              dv_v_r   [DIV_W+1];
  div_side_t         dv_side_r[DIV_W+1];
  logic [DIV_W-1:0]  dv_num_r [DIV_W+1];
  logic [DIV_W-1:0]  dv_rem_r [DIV_W+1];
  logic [DIV_W-1:0]  dv_quo_r [DIV_W+1];
  logic [DIV_W-1:0]  dv_den_r [DIV_W+1];

  // stage 0 loads the numerator (pre-doubled when it fits)
  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (adv) dv_v_r[0] <= s10_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side_r[0].side    <= s10_side_r;
      dv_side_r[0].invalid <= (s10_div_r == '0);
      dv_side_r[0].mode    <= s10_pm_r[31];
      dv_num_r[0]          <= s10_pm_r[31] ? s10_pm_r : {s10_pm_r[30:0], 1'b0};
      dv_rem_r[0]          <= '0;
      dv_quo_r[0]          <= '0;
      dv_den_r[0]          <= s10_div_r;
    end
  end

  for (genvar k = 0; k < DIV_W; k++) begin : g_div
    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           ge;
    assign trial = {dv_rem_r[k], dv_num_r[k][DIV_W-1]};
    assign diff  = trial - {1'b0, dv_den_r[k]};
    assign ge    = (trial >= {1'b0, dv_den_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k+1] <= 1'b0;
      else if (adv) dv_v_r[k+1] <= dv_v_r[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_side_r[k+1] <= dv_side_r[k];
        dv_num_r[k+1]  <= {dv_num_r[k][DIV_W-2:0], 1'b0};
        dv_rem_r[k+1]  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        dv_quo_r[k+1]  <= {dv_quo_r[k][DIV_W-2:0], ge};
        dv_den_r[k+1]  <= dv_den_r[k];
      end
    end
  end

  // ---------------- PA: p, (p>>3)^2, (p>>2)*P8 ----------------
  logic              pa_v_r;
  div_side_t         pa_side_r;
  logic [31:0]       pa_p_r, pa_sq_r, pa_m8_r;
  logic [31:0]       pa_p;
  logic [63:0]       pa_sq;
  logic signed [47:0] pa_m8;
  assign pa_p  = dv_side_r[DIV_W].mode ? {dv_quo_r[DIV_W][30:0], 1'b0} : dv_quo_r[DIV_W];
  assign pa_sq = {3'd0, pa_p[31:3]} * {3'd0, pa_p[31:3]};
  assign pa_m8 = $signed({2'd0, pa_p[31:2]}) * p8;

  always_ff @(posedge clk) begin
    if (!rst_n) pa_v_r <= 1'b0;
    else if (adv) pa_v_r <= dv_v_r[DIV_W];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pa_side_r <= dv_side_r[DIV_W];
      pa_p_r    <= pa_p;
      pa_sq_r   <= pa_sq[31:0];
      pa_m8_r   <= pa_m8[31:0];
    end
  end

  // ---------------- PB: P9 * (sq>>13) ----------------
  logic              pb_v_r;
  div_side_t         pb_side_r;
  logic [31:0]       pb_p_r, pb_m9_r, pb_v2_r;
  logic signed [47:0] pb_m9;
  assign pb_m9 = $signed({13'd0, pa_sq_r[31:13]}) * p9;

  always_ff @(posedge clk) begin
    if (!rst_n) pb_v_r <= 1'b0;
    else if (adv) pb_v_r <= pa_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pb_side_r <= pa_side_r;
      pb_p_r    <= pa_p_r;
      pb_m9_r   <= pb_m9[31:0];
      pb_v2_r   <= $signed(pa_m8_r) >>> 13;
    end
  end

  // ---------------- PC: final correction, select, output register ----------------
  logic [31:0]                 pc_sum, pc_pf;
  logic signed [READING_W-1:0] pc_reading;
  logic                        pc_invalid;
  logic signed [READING_W-1:0] out_reading_r;
  logic                        out_invalid_r;

  // all terms signed so both shifts stay arithmetic
  assign pc_sum = ($signed(pb_m9_r) >>> 12) + $signed(pb_v2_r) + $signed({{16{p7[15]}}, p7});
  assign pc_pf  = $signed(pb_p_r) + ($signed(pc_sum) >>> 4);

  always_comb begin
    pc_invalid = 1'b0;
    priority if (pb_side_r.side.kind == KIND_TEMP) begin
      pc_reading = pb_side_r.side.temp;
    end else if (pb_side_r.invalid) begin
      pc_invalid = 1'b1;
      pc_reading = '0;
    end else if (pc_pf > PRESS_MAX) begin
      pc_reading = READING_W'(PRESS_MAX);
    end else begin
      pc_reading = pc_pf[READING_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= pb_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      out_reading_r <= pc_reading;
      out_invalid_r <= pc_invalid;
    end
  end

  assign out_rsp.valid   = out_valid_r;
  assign out_rsp.reading = out_reading_r;
  assign out_rsp.invalid = out_invalid_r;

endmodule

[rtl/btc_checker.sv]
module btc_checker
  import btc_pkg::*;
(
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [READING_W-1:0] out_reading,
  input logic                        out_invalid
);

  logic [6:0] pend_r;
  logic       in_acc, out_acc;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else pend_r <= pend_r + 7'(in_acc) - 7'(out_acc);
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reading))
    else $error("result dropped under stall");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 7'd0)
    else $error("result without a request");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_reading == '0)
    else $error("invalid result with nonzero reading");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind baro_temp_compensation btc_checker u_btc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .out_reading (out_rsp.reading),
  .out_invalid (out_rsp.invalid)
);
